// ===== rtl/efr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efr_pkg
// Shared types and constants for the escaped frame receiver.
// ----------------------------------------------------------------------------
package efr_pkg;

   localparam logic [7:0] HEAD_BYTE      = 8'hAA;
   localparam logic [7:0] ESC_BYTE       = 8'h55;
   localparam logic [7:0] MANGLE_BYTE    = 8'h20;
   localparam logic [7:0] REPEAT_SAT     = 8'hFF;
   localparam logic [7:0] MAX_REPEATS_RST = 8'd100;

   typedef enum logic [1:0] {
      KIND_BODY     = 2'd0,
      KIND_ACCEPT   = 2'd1,
      KIND_MISMATCH = 2'd2,
      KIND_SYNC     = 2'd3
   } efr_kind_type;

   typedef struct packed {
      logic         valid;
      efr_kind_type kind;
      logic [7:0]   data;
      logic [15:0]  length;
   } efr_result_type;

endpackage

// ===== rtl/efr_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efr_decoder
// Frame parse state and per-byte decode: head hunt, unescape, length, body,
// checksum. Produces at most one result per consumed byte.
// ----------------------------------------------------------------------------
module efr_decoder (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             in_byte,
   input  logic [7:0]             max_repeats,
   output efr_pkg::efr_result_type result
);
   import efr_pkg::*;

   typedef enum logic [5:0] {
      PH_HUNT   = 6'b000001,
      PH_LEN_LO = 6'b000010,
      PH_LEN_HI = 6'b000100,
      PH_BODY   = 6'b001000,
      PH_CK_LO  = 6'b010000,
      PH_CK_HI  = 6'b100000
   } efr_phase_type;

   efr_phase_type phase_ff, phase_in;
   logic          esc_ff, esc_in;
   logic [7:0]    prev_ff, prev_in;
   logic [7:0]    rep_ff, rep_in;
   logic [15:0]   body_len_ff, body_len_in;
   logic [15:0]   remaining_ff, remaining_in;
   logic [15:0]   sum_ff, sum_in;
   logic [7:0]    ck_low_ff, ck_low_in;

   logic [7:0]    value;
   logic [15:0]   rem_dec;
   logic [15:0]   got;
   logic [15:0]   want;

   assign value   = esc_ff ? (in_byte ^ MANGLE_BYTE) : in_byte;
   assign rem_dec = remaining_ff - 16'd1;
   assign got     = {value, ck_low_ff};
   assign want    = 16'd0 - sum_ff;

   always_comb begin
      phase_in     = phase_ff;
      esc_in       = esc_ff;
      prev_in      = prev_ff;
      rep_in       = rep_ff;
      body_len_in  = body_len_ff;
      remaining_in = remaining_ff;
      sum_in       = sum_ff;
      ck_low_in    = ck_low_ff;
      result       = '{valid: 1'b0, kind: KIND_BODY, data: 8'd0, length: 16'd0};

      if (phase_ff == PH_HUNT) begin
         if (rep_ff > max_repeats) begin
            // byte is dropped, hunt restarts
            prev_in      = 8'd0;
            rep_in       = 8'd0;
            esc_in       = 1'b0;
            result.valid = 1'b1;
            result.kind  = KIND_SYNC;
         end else begin
            if (in_byte == prev_ff && rep_ff != REPEAT_SAT) begin
               rep_in = rep_ff + 8'd1;
            end
            prev_in = in_byte;
            if (in_byte == HEAD_BYTE) begin
               phase_in = PH_LEN_LO;
               esc_in   = 1'b0;
               sum_in   = 16'd0;
            end
         end
      end else if (!esc_ff && in_byte == ESC_BYTE) begin
         esc_in = 1'b1;
      end else begin
         esc_in = 1'b0;
         unique case (phase_ff)
            PH_LEN_LO: begin
               body_len_in = {8'd0, value};
               sum_in      = {8'd0, value};
               phase_in    = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               body_len_in  = {value, body_len_ff[7:0]};
               remaining_in = {value, body_len_ff[7:0]};
               sum_in       = sum_ff + {8'd0, value};
               phase_in     = ({value, body_len_ff[7:0]} == 16'd0) ? PH_CK_LO : PH_BODY;
            end
            PH_BODY: begin
               sum_in       = sum_ff + {8'd0, value};
               remaining_in = rem_dec;
               if (rem_dec == 16'd0) begin
                  phase_in = PH_CK_LO;
               end
               result.valid = 1'b1;
               result.kind  = KIND_BODY;
               result.data  = value;
            end
            PH_CK_LO: begin
               ck_low_in = value;
               phase_in  = PH_CK_HI;
            end
            PH_CK_HI: begin
               phase_in      = PH_HUNT;
               prev_in       = 8'd0;
               rep_in        = 8'd0;
               result.valid  = 1'b1;
               result.kind   = (got == want) ? KIND_ACCEPT : KIND_MISMATCH;
               result.length = body_len_ff;
            end
            default: begin
               phase_in = PH_HUNT;
               prev_in  = 8'd0;
               rep_in   = 8'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         esc_ff       <= 1'b0;
         prev_ff      <= 8'd0;
         rep_ff       <= 8'd0;
         body_len_ff  <= 16'd0;
         remaining_ff <= 16'd0;
         sum_ff       <= 16'd0;
         ck_low_ff    <= 8'd0;
      end else if (step) begin
         phase_ff     <= phase_in;
         esc_ff       <= esc_in;
         prev_ff      <= prev_in;
         rep_ff       <= rep_in;
         body_len_ff  <= body_len_in;
         remaining_ff <= remaining_in;
         sum_ff       <= sum_in;
         ck_low_ff    <= ck_low_in;
      end
   end

   // escape state only lives inside a frame
   a_hunt_no_esc: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HUNT |-> !esc_ff)
      else $error("escape pending while hunting");

   a_body_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> remaining_ff != 16'd0)
      else $error("body phase with no bytes left");

   a_status_to_hunt: assert property (@(posedge clock) disable iff (reset)
      step && result.valid && result.kind != KIND_BODY |=> phase_ff == PH_HUNT)
      else $error("status result did not return to hunt");

endmodule

// ===== rtl/escaped_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_frame_receiver
// Byte-stuffed frame decoder with 16-bit sum checksum.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one raw serial byte per request (valid/stall).
//   rsp_*  : decoded results: body bytes, then one status per frame
//            (accepted, checksum mismatch) or a sync-hunt failure.
//   csr_*  : write of max_repeats, always ready; write only while idle.
// A request lands in an input register, is decoded by single-pass logic and
// its result (if any) is written to the output register, which drives
// rsp_valid. Throughput is one byte per cycle while no result waits on
// rsp_stall, set by the single decode pass between the two registers.
// Reset (synchronous) returns to head hunt, clears all parse state and sets
// max_repeats to 100. When rsp_stall holds a waiting result, the input
// register still takes one more request; the next request is stalled until
// the output register frees up. Bytes yielding no result never wait on rsp.
// ----------------------------------------------------------------------------
module escaped_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_out_kind,
   output logic [7:0]  rsp_out_byte,
   output logic [15:0] rsp_frame_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_max_repeats
);
   import efr_pkg::*;

   logic           in_vld_ff;
   logic [7:0]     in_byte_ff;
   logic [7:0]     max_rep_ff;
   logic           out_vld_ff;
   efr_kind_type   out_kind_ff;
   logic [7:0]     out_byte_ff;
   logic [15:0]    out_len_ff;
   efr_result_type result;
   logic           out_free;
   logic           advance;

   assign csr_ready = 1'b1;
   assign out_free  = !out_vld_ff || !rsp_stall;
   assign advance   = in_vld_ff && (out_free || !result.valid);
   assign req_stall = in_vld_ff && !advance;

   efr_decoder u_decoder (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .in_byte     (in_byte_ff),
      .max_repeats (max_rep_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_rep_ff <= MAX_REPEATS_RST;
      end else if (csr_valid && csr_ready) begin
         max_rep_ff <= csr_max_repeats;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_vld_ff <= 1'b1;
      end else if (advance) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance && result.valid) begin
         out_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         out_kind_ff <= result.kind;
         out_byte_ff <= result.data;
         out_len_ff  <= result.length;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_out_kind     = out_kind_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_frame_length = out_len_ff;

   a_status_byte_zero: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_kind_ff != KIND_BODY |-> out_byte_ff == 8'd0)
      else $error("status result carries a data byte");

   a_len_zero: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && (out_kind_ff == KIND_BODY || out_kind_ff == KIND_SYNC)
      |-> out_len_ff == 16'd0)
      else $error("length set on body or sync result");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !advance |=> in_vld_ff && $stable(in_byte_ff))
      else $error("waiting request lost from input register");

endmodule

// ===== verif/escaped_frame_receiver_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_frame_receiver_test
// Self-checking bench for the byte-stuffed frame receiver. Raw bytes are
// pushed through the request port while a scoreboard decodes the same stream
// (head hunt, repeat counting, escapes, length, body, checksum) and compares
// every response field. Runs a short directed opening, then randomized frames,
// noise and damaged frames under several max_repeats settings with random
// request/response idling and one long response back-pressure window.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_test;
   import efr_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 10;
   localparam int DRAIN_CYCLES = 4;
   localparam int END_CYCLES   = 8;
   localparam int HOLD_CYCLES  = 200;
   localparam int IDLE_LIMIT   = 2000;

   typedef enum logic [2:0] {
      PH_HUNT, PH_LEN_LO, PH_LEN_HI, PH_BODY, PH_SUM_LO, PH_SUM_HI
   } parse_phase_type;

   typedef struct {
      efr_kind_type kind;
      logic [7:0]   data;
      logic [15:0]  frame_len;
   } outcome_type;

   // Tracks the decoder state and the responses it still owes.
   class frame_decode_board_type;
      logic [7:0]      repeat_limit;
      parse_phase_type phase;
      bit              esc_open;
      logic [7:0]      last_byte;
      logic [7:0]      repeats;
      logic [15:0]     body_len;
      logic [15:0]     left;
      logic [15:0]     running_total;
      logic [7:0]      sum_lo_byte;
      outcome_type     pending_outcomes[$];
      int              errors;

      function new();
         repeat_limit  = MAX_REPEATS_RST;
         body_len      = '0;
         left          = '0;
         running_total = '0;
         sum_lo_byte   = '0;
         errors        = 0;
         restart();
      endfunction

      function void restart();
         phase     = PH_HUNT;
         esc_open  = 1'b0;
         last_byte = '0;
         repeats   = '0;
      endfunction

      function void set_limit(logic [7:0] value);
         repeat_limit = value;
      endfunction

      function int pending();
         return pending_outcomes.size();
      endfunction

      function bit sync_due();
         return (phase == PH_HUNT) && (repeats > repeat_limit);
      endfunction

      function void owe(efr_kind_type kind, logic [7:0] data, logic [15:0] len);
         outcome_type o;
         o.kind      = kind;
         o.data      = data;
         o.frame_len = len;
         pending_outcomes.push_back(o);
      endfunction

      function void note_request(logic [7:0] raw);
         logic [7:0]  b;
         logic [15:0] got;
         logic [15:0] want;
         b = raw;
         if (phase == PH_HUNT) begin
            // the byte arriving past the repeat limit is swallowed
            if (repeats > repeat_limit) begin
               restart();
               owe(KIND_SYNC, 8'h00, 16'h0000);
               return;
            end
            if (b == last_byte && repeats != REPEAT_SAT)
               repeats = repeats + 8'd1;
            last_byte = b;
            if (b == HEAD_BYTE) begin
               phase         = PH_LEN_LO;
               esc_open      = 1'b0;
               running_total = '0;
            end
            return;
         end
         if (!esc_open && b == ESC_BYTE) begin
            esc_open = 1'b1;
            return;
         end
         if (esc_open) begin
            b        = b ^ MANGLE_BYTE;
            esc_open = 1'b0;
         end
         case (phase)
            PH_LEN_LO: begin
               body_len      = {8'h00, b};
               running_total = {8'h00, b};
               phase         = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               body_len[15:8] = b;
               running_total  = running_total + {8'h00, b};
               left           = body_len;
               phase          = (left == 16'h0000) ? PH_SUM_LO : PH_BODY;
            end
            PH_BODY: begin
               running_total = running_total + {8'h00, b};
               left          = left - 16'd1;
               if (left == 16'h0000)
                  phase = PH_SUM_LO;
               owe(KIND_BODY, b, 16'h0000);
            end
            PH_SUM_LO: begin
               sum_lo_byte = b;
               phase       = PH_SUM_HI;
            end
            default: begin
               got  = {b, sum_lo_byte};
               want = 16'h0000 - running_total;
               restart();
               owe((got == want) ? KIND_ACCEPT : KIND_MISMATCH, 8'h00, body_len);
            end
         endcase
      endfunction

      function void check_result(logic [1:0] kind, logic [7:0] data, logic [15:0] len);
         outcome_type e;
         if (pending_outcomes.size() == 0) begin
            $error("unexpected response: kind %0d byte 0x%02h length %0d", kind, data, len);
            errors++;
            return;
         end
         e = pending_outcomes.pop_front();
         if (kind !== e.kind) begin
            $error("out_kind: expected %0d, actual %0d", e.kind, kind);
            errors++;
         end
         if (data !== e.data) begin
            $error("out_byte: expected 0x%02h, actual 0x%02h", e.data, data);
            errors++;
         end
         if (len !== e.frame_len) begin
            $error("frame_length: expected %0d, actual %0d", e.frame_len, len);
            errors++;
         end
      endfunction
   endclass

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte     = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [1:0]  rsp_out_kind;
   logic [7:0]  rsp_out_byte;
   logic [15:0] rsp_frame_length;
   logic        csr_valid       = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_max_repeats = 8'h00;

   frame_decode_board_type decode_board = new();

   int gap_odds      = 0;
   int stall_odds    = 0;
   bit steady        = 1'b0;
   bit hold_req      = 1'b0;
   int sent_items    = 0;
   int silent_cycles = 0;

   escaped_frame_receiver u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_kind     (rsp_out_kind),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_frame_length (rsp_frame_length),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_max_repeats  (csr_max_repeats)
   );

   always #HALF_PERIOD clock = ~clock;

   // Response side: random stall bursts, plus one long hold when asked.
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall = 1'b0;
            hold_req  = 1'b0;
         end else if (!steady && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            n         = $urandom_range(1, 16);
            rsp_stall = 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         decode_board.check_result(rsp_out_kind, rsp_out_byte, rsp_frame_length);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         silent_cycles <= 0;
      end else if (silent_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         silent_cycles <= silent_cycles + 1;
      end
   end

   // All driving tasks are entered and left at a falling edge.
   task automatic send_byte(input logic [7:0] b);
      int n;
      if (!steady && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         n         = $urandom_range(1, 16);
         req_valid = 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_in_byte = b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_board.note_request(b);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (decode_board.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(input logic [7:0] value);
      drain();
      csr_valid       = 1'b1;
      csr_max_repeats = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      decode_board.set_limit(value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return ESC_BYTE;
         3:       return HEAD_BYTE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Hunt-safe filler: never a head byte, never an escape.
   function automatic logic [7:0] line_noise();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == HEAD_BYTE || b == ESC_BYTE)
         b = 8'h3C;
      return b;
   endfunction

   task automatic send_field(input logic [7:0] b);
      if (b == ESC_BYTE || $urandom_range(0, 7) == 0) begin
         send_byte(ESC_BYTE);
         send_byte(b ^ MANGLE_BYTE);
      end else begin
         send_byte(b);
      end
   endtask

   // cut >= 0 drops the tail after that many body bytes and fills the gap
   // with line noise so the decoder lands back in the hunt.
   task automatic send_frame(input int len, input int cut, input bit bad_sum);
      logic [15:0] n16;
      logic [15:0] total;
      logic [7:0]  d;
      n16 = 16'(len);
      if (decode_board.sync_due())
         send_byte(8'h3C);
      send_byte(HEAD_BYTE);
      send_field(n16[7:0]);
      send_field(n16[15:8]);
      total = {8'h00, n16[7:0]} + {8'h00, n16[15:8]};
      for (int i = 0; i < len; i++) begin
         if (i == cut) begin
            repeat (len - cut + 2) send_byte(line_noise());
            return;
         end
         d     = pick_byte();
         total = total + {8'h00, d};
         send_field(d);
      end
      total = 16'h0000 - total;
      if (bad_sum)
         total = total ^ (16'h0001 << $urandom_range(0, 15));
      send_field(total[7:0]);
      send_field(total[15:8]);
   endtask

   task automatic send_run(input int n);
      logic [7:0] b;
      b = line_noise();
      repeat (n) send_byte(b);
   endtask

   task automatic run_phase(input int upto, input int max_len);
      int len;
      while (sent_items < upto) begin
         len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, max_len)
                                            : $urandom_range(0, 12);
         case ($urandom_range(0, 19))
            14, 15: send_frame(len, -1, 1'b1);
            16:     send_frame(len + 2, $urandom_range(0, len + 1), 1'b0);
            17, 18: repeat ($urandom_range(1, 4)) send_run($urandom_range(1, 8));
            19: begin
               if (decode_board.repeat_limit < 60)
                  send_run($urandom_range(1, decode_board.repeat_limit + 3));
               else
                  send_run($urandom_range(1, 20));
            end
            default: send_frame(len, -1, 1'b0);
         endcase
      end
   endtask

   initial begin
      logic [7:0] opening [22];
      opening = '{HEAD_BYTE, 8'h03, 8'h00, 8'h00, 8'hFF, ESC_BYTE, 8'h75, 8'hA9, 8'hFE,
                  HEAD_BYTE, ESC_BYTE, 8'h20, 8'h00, 8'h00, 8'h00,
                  HEAD_BYTE, 8'h01, 8'h00, ESC_BYTE, ESC_BYTE, 8'h00, 8'h00};
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // escaped 0x55 body byte, escaped zero length, escape of an escape,
      // bad checksum
      foreach (opening[i]) send_byte(opening[i]);
      // zero limit: one leading zero repeat, the head byte after it is dropped
      write_limit(8'd0);
      send_byte(8'h00);
      send_byte(HEAD_BYTE);

      // top limit: repeat counter saturates and never trips
      write_limit(8'd255);
      gap_odds   = 4;
      stall_odds = 4;
      send_run(270);
      run_phase(480, 40);

      write_limit(8'd3);
      gap_odds   = 0;
      stall_odds = 0;
      run_phase(650, 30);

      // long response hold with the request side kept busy
      write_limit(MAX_REPEATS_RST);
      hold_req = 1'b1;
      while (sent_items < 820) send_frame($urandom_range(20, 40), -1, 1'b0);

      write_limit(8'd100);
      gap_odds   = 8;
      stall_odds = 3;
      send_run(110);
      send_frame(300, -1, 1'b0);
      run_phase(1200, 40);

      write_limit(8'($urandom_range(1, 254)));
      gap_odds   = 2;
      stall_odds = 8;
      run_phase(1320, 30);

      write_limit(8'd0);
      gap_odds   = 6;
      stall_odds = 6;
      run_phase(1440, 30);

      write_limit(8'd1);
      steady = 1'b1;
      run_phase(1560, 30);

      drain();
      repeat (END_CYCLES) @(negedge clock);
      if (decode_board.errors == 0 && decode_board.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
